// ===== hw/rtl/whfp_pkg.sv =====
// ----------------------------------------------------------------------------
// whfp_pkg: shared types and constants for the wave height field point unit
// Pipeline payload, config register indexes, fixed-point constants, CORDIC
// arctangent table and the quarter-turn fold used by both wave paths.
// ----------------------------------------------------------------------------
package whfp_pkg;

  // Config register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_STRAIGHT_WL   = 3'd0;
  localparam logic [2:0] REG_STRAIGHT_GAIN = 3'd1;
  localparam logic [2:0] REG_RING_WL       = 3'd2;
  localparam logic [2:0] REG_RING_GAIN     = 3'd3;
  localparam logic [2:0] REG_RING_ORG_X    = 3'd4;
  localparam logic [2:0] REG_RING_ORG_Z    = 3'd5;
  localparam logic [2:0] REG_GRAVITY       = 3'd6;

  // Fixed-point constants
  localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;   // 2^32 / (2 pi)
  localparam logic [31:0] INV_SQRT2_Q32   = 32'd3037000500;  // 2^32 / sqrt2
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [17:0] DIV7_MUL        = 18'd149797;      // ceil(2^20 / 7)
  localparam logic [47:0] HT_RND          = 48'h0000_7000_0000; // 7 * 2^28

  // Rate unit state
  typedef enum logic [1:0] {
    CU_IDLE,
    CU_DIV,
    CU_SQRT
  } cu_state_e;

  // Payload carried down the pipeline
  typedef struct packed {
    logic [15:0]        px;
    logic [15:0]        pz;
    logic [31:0]        ts;
    logic [31:0]        tr;
    logic               act;
    logic               s_neg;
    logic [16:0]        s_abs;
    logic signed [16:0] dx;
    logic signed [16:0] dz;
    logic [48:0]        mag;
    logic [33:0]        dxx;
    logic [33:0]        dzz;
    logic [31:0]        ph_s;
    logic [50:0]        ph_r;
    logic [55:0]        sq_v;
    logic [55:0]        sq_r;
    logic [7:0]         rem_s;
    logic [42:0]        quo_s;
    logic [7:0]         rem_r;
    logic [43:0]        quo_r;
    logic               ring_en;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [32:0] zs;
    logic signed [33:0] xr;
    logic signed [33:0] yr;
    logic signed [32:0] zr;
    logic [46:0]        ms;
    logic [46:0]        mr;
    logic [18:0]        vs;
    logic [18:0]        vr;
    logic signed [16:0] hs;
    logic signed [16:0] hr;
    logic signed [15:0] height;
    logic               sat;
  } pipe_t;

  // CORDIC arctangent, Q.32 turns
  function automatic logic [29:0] atan_turns(input int i);
    logic [29:0] r;
    case (i)
      0:       r = 30'd536870912;
      1:       r = 30'd316933406;
      2:       r = 30'd167458907;
      3:       r = 30'd85004756;
      4:       r = 30'd42667331;
      5:       r = 30'd21354465;
      6:       r = 30'd10679838;
      7:       r = 30'd5340245;
      8:       r = 30'd2670163;
      9:       r = 30'd1335087;
      10:      r = 30'd667544;
      11:      r = 30'd333772;
      12:      r = 30'd166886;
      13:      r = 30'd83443;
      14:      r = 30'd41722;
      15:      r = 30'd20861;
      16:      r = 30'd10430;
      17:      r = 30'd5215;
      18:      r = 30'd2608;
      19:      r = 30'd1304;
      20:      r = 30'd652;
      21:      r = 30'd326;
      22:      r = 30'd163;
      23:      r = 30'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Fold an angle into [-1/4, 1/4] turn, keeping the sine
  function automatic logic signed [32:0] fold_turns(input logic [31:0] a);
    logic signed [32:0] z;
    z = $signed({a[31], a});
    if (z > 33'sd1073741824) begin
      z = 33'sd2147483648 - z;
    end else if (z < -33'sd1073741824) begin
      z = -33'sd2147483648 - z;
    end
    return z;
  endfunction

endpackage

// ===== hw/rtl/wave_height_field_point_unit.sv =====
// ----------------------------------------------------------------------------
// wave_height_field_point_unit: water surface height at one grid point
// Sum of a straight sine wave and a ring pulse, Q9.6 fixed point, saturated.
// ----------------------------------------------------------------------------
// Pipeline: input transfer reaches output valid through the bit-serial dividers
//   and square root stages and the CORDIC steps (capped at 24).
// Throughput: one point per cycle outside a rate pass; the whole pipeline
//   holds on output stall.
// Reset: a rate unit derives both wave rates from the registers in 62 divide
//   steps, 31 square root steps and one start step; s_axis_tready stays low
//   meanwhile. The same pass reruns after every register write.
module wave_height_field_point_unit #(
  parameter int SINE_ITERATIONS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // point_x, point_z, straight_time, ring_time
  input  logic [0:0]   s_axis_tuser,   // ring_active
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // height
  output logic [0:0]   m_axis_tuser,   // saturated
  // config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // CORDIC steps, at most one per arctangent table entry
  localparam int N_COR  = (SINE_ITERATIONS < 24) ? SINE_ITERATIONS : 24;
  localparam int K_ANG  = 76;
  localparam int K_COR  = K_ANG + 1;
  localparam int K_MUL  = K_COR + N_COR;
  localparam int K_RND  = K_MUL + 1;
  localparam int K_HGT  = K_RND + 1;
  localparam int K_SUM  = K_HGT + 1;
  localparam int NST    = K_SUM + 1;

  // --------------------------------------------------------------------------
  // Config registers
  logic [7:0]  swl_q, sgain_q, rwl_q, rgain_q;
  logic [15:0] orgx_q, orgz_q, grav_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swl_q   <= 8'd50;
      sgain_q <= 8'd8;
      rwl_q   <= 8'd40;
      rgain_q <= 8'd64;
      orgx_q  <= '0;
      orgz_q  <= '0;
      grav_q  <= 16'd2509;
    end else if (wr_en) begin
      case (paddr[4:2])
        whfp_pkg::REG_STRAIGHT_WL:   swl_q   <= pwdata[7:0];
        whfp_pkg::REG_STRAIGHT_GAIN: sgain_q <= pwdata[7:0];
        whfp_pkg::REG_RING_WL:       rwl_q   <= pwdata[7:0];
        whfp_pkg::REG_RING_GAIN:     rgain_q <= pwdata[7:0];
        whfp_pkg::REG_RING_ORG_X:    orgx_q  <= pwdata[15:0];
        whfp_pkg::REG_RING_ORG_Z:    orgz_q  <= pwdata[15:0];
        whfp_pkg::REG_GRAVITY:       grav_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:2])
      whfp_pkg::REG_STRAIGHT_WL:   prdata = {24'b0, swl_q};
      whfp_pkg::REG_STRAIGHT_GAIN: prdata = {24'b0, sgain_q};
      whfp_pkg::REG_RING_WL:       prdata = {24'b0, rwl_q};
      whfp_pkg::REG_RING_GAIN:     prdata = {24'b0, rgain_q};
      whfp_pkg::REG_RING_ORG_X:    prdata = {16'b0, orgx_q};
      whfp_pkg::REG_RING_ORG_Z:    prdata = {16'b0, orgz_q};
      whfp_pkg::REG_GRAVITY:       prdata = {16'b0, grav_q};
      default:                     prdata = '0;
    endcase
  end

  // Effective wavelengths (zero acts as one) and gain * raw wavelength products
  logic [7:0]  len_s, len_r;
  logic [15:0] gl_s_q, gl_r_q;

  assign len_s = (swl_q == 8'd0) ? 8'd1 : swl_q;
  assign len_r = (rwl_q == 8'd0) ? 8'd1 : rwl_q;

  always_ff @(posedge clk_i) begin
    gl_s_q <= 16'(sgain_q) * 16'(swl_q);
    gl_r_q <= 16'(rgain_q) * 16'(rwl_q);
  end

  // --------------------------------------------------------------------------
  // Rate unit: rate = isqrt(g * IV * 2^16 / L) for both waves, bit serial
  whfp_pkg::cu_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        start_q, start_d;
  logic [61:0] num_q [2];
  logic [61:0] num_d [2];
  logic [7:0]  rem_q [2];
  logic [7:0]  rem_d [2];
  logic [61:0] rq_q [2];
  logic [61:0] rq_d [2];
  logic [30:0] rate_q [2];
  logic [30:0] rate_d [2];
  logic        busy;

  assign busy = start_q || (state_q != whfp_pkg::CU_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= whfp_pkg::CU_IDLE;
      cnt_q   <= '0;
      start_q <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    rq_q   <= rq_d;
    rate_q <= rate_d;
  end

  always_comb begin
    logic [61:0] ninit;
    logic [7:0]  le [2];
    logic [8:0]  dt;
    logic        ge;
    logic [61:0] bq;
    logic [62:0] rt;
    state_d = state_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    num_d   = num_q;
    rem_d   = rem_q;
    rq_d    = rq_q;
    rate_d  = rate_q;
    le[0]   = len_s;
    le[1]   = len_r;
    ninit   = {46'({30'b0, grav_q} * {16'b0, whfp_pkg::INV_TWO_PI_Q32}), 16'b0};
    bq      = 62'(1) << {cnt_q[4:0], 1'b0};
    case (state_q)
      whfp_pkg::CU_IDLE: begin
        if (start_q) begin
          start_d = 1'b0;
          for (int w = 0; w < 2; w++) begin
            num_d[w] = ninit;
            rem_d[w] = '0;
          end
          cnt_d   = 6'd61;
          state_d = whfp_pkg::CU_DIV;
        end
      end
      whfp_pkg::CU_DIV: begin
        for (int w = 0; w < 2; w++) begin
          dt = {rem_q[w], num_q[w][61]};
          ge = (dt >= {1'b0, le[w]});
          rem_d[w] = ge ? 8'(dt - {1'b0, le[w]}) : dt[7:0];
          num_d[w] = {num_q[w][60:0], ge};
          rq_d[w]  = '0;
        end
        if (cnt_q == 6'd0) begin
          cnt_d   = 6'd30;
          state_d = whfp_pkg::CU_SQRT;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      whfp_pkg::CU_SQRT: begin
        for (int w = 0; w < 2; w++) begin
          rt = {1'b0, rq_q[w]} + {1'b0, bq};
          if ({1'b0, num_q[w]} >= rt) begin
            num_d[w] = num_q[w] - rt[61:0];
            rq_d[w]  = (rq_q[w] >> 1) + bq;
          end else begin
            rq_d[w]  = rq_q[w] >> 1;
          end
          if (cnt_q == 6'd0) begin
            rate_d[w] = rq_d[w][30:0];
          end
        end
        if (cnt_q == 6'd0) begin
          state_d = whfp_pkg::CU_IDLE;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      default: state_d = whfp_pkg::CU_IDLE;
    endcase
    if (wr_en) begin
      start_d = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances unless the output holds a stalled item
  logic [NST-1:0]  vld_q;
  whfp_pkg::pipe_t pipe_q [NST];
  whfp_pkg::pipe_t nxt    [NST];
  logic            en, in_xfer;

  assign en            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en && !busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_xfer};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q <= nxt;
    end
  end

  // Input capture
  always_comb begin
    nxt[0]     = '0;
    nxt[0].px  = s_axis_tdata[15:0];
    nxt[0].pz  = s_axis_tdata[31:16];
    nxt[0].ts  = s_axis_tdata[63:32];
    nxt[0].tr  = s_axis_tdata[95:64];
    nxt[0].act = s_axis_tuser[0];
  end

  // Stage logic, one step of each running operation per stage
  for (genvar k = 1; k < NST; k++) begin : g_stage
    whfp_pkg::pipe_t n;

    always_comb begin
      logic [16:0]        sum17;
      logic signed [33:0] dxw, dzw;
      logic [62:0]        prod_s, prod_r;
      logic [34:0]        sq35;
      logic [55:0]        bq;
      logic [56:0]        rt;
      logic [8:0]         dt;
      logic               ge;
      logic [31:0]        per32, ang_s, ang_r;
      logic [51:0]        rdiff;
      logic signed [33:0] ddx, ddy, ya;
      logic signed [32:0] at;
      logic [47:0]        rs48, rr48;
      logic [36:0]        pq;
      logic [16:0]        q;
      logic signed [17:0] s18;
      n      = pipe_q[k-1];
      sum17  = '0;
      dxw    = '0;
      dzw    = '0;
      prod_s = '0;
      prod_r = '0;
      sq35   = '0;
      bq     = '0;
      rt     = '0;
      dt     = '0;
      ge     = 1'b0;
      per32  = '0;
      ang_s  = '0;
      ang_r  = '0;
      rdiff  = '0;
      ddx    = '0;
      ddy    = '0;
      ya     = '0;
      at     = '0;
      rs48   = '0;
      rr48   = '0;
      pq     = '0;
      q      = '0;
      s18    = '0;

      // Sum along (1,1) and offsets from the ring center
      if (k == 1) begin
        sum17   = 17'($signed(n.px)) + 17'($signed(n.pz));
        n.s_neg = sum17[16];
        n.s_abs = sum17[16] ? 17'(-sum17) : sum17;
        n.dx    = 17'($signed(n.px)) - 17'($signed(orgx_q));
        n.dz    = 17'($signed(n.pz)) - 17'($signed(orgz_q));
      end

      // Products: projected distance, squares, phases
      if (k == 2) begin
        n.mag  = 49'(n.s_abs) * 49'(whfp_pkg::INV_SQRT2_Q32);
        dxw    = 34'(n.dx);
        dzw    = 34'(n.dz);
        n.dxx  = 34'(dxw * dxw);
        n.dzz  = 34'(dzw * dzw);
        prod_s = 63'(n.ts) * 63'(rate_q[0]);
        prod_r = 63'(n.tr) * 63'(rate_q[1]);
        n.ph_s = prod_s[43:12];
        n.ph_r = prod_r[62:12];
      end

      // Square root and straight divide setup
      if (k == 3) begin
        sq35    = 35'(n.dxx) + 35'(n.dzz);
        n.sq_v  = {1'b0, sq35, 20'b0};
        n.sq_r  = '0;
        n.quo_s = n.mag[48:6];
        n.rem_s = '0;
      end

      // Ring distance square root, one result bit per stage
      if (k >= 4 && k <= 31) begin
        bq = 56'(1) << (2 * (31 - k));
        rt = {1'b0, n.sq_r} + {1'b0, bq};
        if ({1'b0, n.sq_v} >= rt) begin
          n.sq_v = n.sq_v - rt[55:0];
          n.sq_r = (n.sq_r >> 1) + bq;
        end else begin
          n.sq_r = n.sq_r >> 1;
        end
        if (k == 31) begin
          n.quo_r = {n.sq_r[27:0], 16'b0};
          n.rem_r = '0;
        end
      end

      // Straight period divide by wavelength
      if (k >= 4 && k <= 46) begin
        dt      = {n.rem_s, n.quo_s[42]};
        ge      = (dt >= {1'b0, len_s});
        n.rem_s = ge ? 8'(dt - {1'b0, len_s}) : dt[7:0];
        n.quo_s = {n.quo_s[41:0], ge};
      end

      // Ring period divide by wavelength
      if (k >= 32 && k <= 75) begin
        dt      = {n.rem_r, n.quo_r[43]};
        ge      = (dt >= {1'b0, len_r});
        n.rem_r = ge ? 8'(dt - {1'b0, len_r}) : dt[7:0];
        n.quo_r = {n.quo_r[42:0], ge};
      end

      // Angles, ring window, fold and CORDIC start
      if (k == K_ANG) begin
        per32     = n.s_neg ? 32'(-n.quo_s[31:0]) : n.quo_s[31:0];
        ang_s     = per32 - n.ph_s;
        rdiff     = {1'b0, n.ph_r} - 52'(n.quo_r);
        n.ring_en = n.act && !rdiff[51] && (rdiff[50:32] == '0);
        ang_r     = n.quo_r[31:0] - n.ph_r[31:0];
        n.zs      = whfp_pkg::fold_turns(ang_s);
        n.zr      = whfp_pkg::fold_turns(ang_r);
        n.xs      = whfp_pkg::CORDIC_GAIN_Q30;
        n.xr      = whfp_pkg::CORDIC_GAIN_Q30;
        n.ys      = '0;
        n.yr      = '0;
      end

      // CORDIC rotation step
      if (k >= K_COR && k < K_MUL) begin
        at  = $signed({3'b0, whfp_pkg::atan_turns(k - K_COR)});
        ddx = n.ys >>> (k - K_COR);
        ddy = n.xs >>> (k - K_COR);
        if (n.zs >= 0) begin
          n.xs = n.xs - ddx;
          n.ys = n.ys + ddy;
          n.zs = n.zs - at;
        end else begin
          n.xs = n.xs + ddx;
          n.ys = n.ys - ddy;
          n.zs = n.zs + at;
        end
        ddx = n.yr >>> (k - K_COR);
        ddy = n.xr >>> (k - K_COR);
        if (n.zr >= 0) begin
          n.xr = n.xr - ddx;
          n.yr = n.yr + ddy;
          n.zr = n.zr - at;
        end else begin
          n.xr = n.xr + ddx;
          n.yr = n.yr - ddy;
          n.zr = n.zr + at;
        end
      end

      // Sine magnitude times gain * wavelength
      if (k == K_MUL) begin
        ya   = n.ys[33] ? -n.ys : n.ys;
        n.ms = 47'(ya[30:0]) * 47'(gl_s_q);
        ya   = n.yr[33] ? -n.yr : n.yr;
        n.mr = 47'(ya[30:0]) * 47'(gl_r_q);
      end

      // Round half up and drop 2^29
      if (k == K_RND) begin
        rs48 = 48'(n.ms) + whfp_pkg::HT_RND;
        rr48 = 48'(n.mr) + whfp_pkg::HT_RND;
        n.vs = rs48[47:29];
        n.vr = rr48[47:29];
      end

      // Divide by 7 via reciprocal, restore sign; ring term zero unless the ring is enabled
      if (k == K_HGT) begin
        pq   = 37'(n.vs) * 37'(whfp_pkg::DIV7_MUL);
        q    = pq[36:20];
        n.hs = n.ys[33] ? $signed(-q) : $signed(q);
        pq   = 37'(n.vr) * 37'(whfp_pkg::DIV7_MUL);
        q    = pq[36:20];
        n.hr = !n.ring_en ? 17'sd0 : (n.yr[33] ? $signed(-q) : $signed(q));
      end

      // Sum and saturate
      if (k == K_SUM) begin
        s18 = 18'(n.hs) + 18'(n.hr);
        if (!s18[17] && (s18[16:15] != 2'b00)) begin
          n.height = 16'sh7fff;
          n.sat    = 1'b1;
        end else if (s18[17] && (s18[16:15] != 2'b11)) begin
          n.height = 16'sh8000;
          n.sat    = 1'b1;
        end else begin
          n.height = s18[15:0];
          n.sat    = 1'b0;
        end
      end
    end

    assign nxt[k] = n;
  end

  // Result stream
  assign m_axis_tvalid   = vld_q[NST-1];
  assign m_axis_tdata    = pipe_q[NST-1].height;
  assign m_axis_tuser[0] = pipe_q[NST-1].sat;

endmodule

// ===== hw/rtl/whfp_checker.sv =====
// ----------------------------------------------------------------------------
// whfp_checker: port-level checks for the wave height field point unit
// Watches the streams and the config port; bound to the top level.
// ----------------------------------------------------------------------------
module whfp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [95:0]  s_axis_tdata,
  input logic [0:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [15:0]  m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [4:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Saturation flag only with a clipped height
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000))
    else $error("saturated flag with unclipped height");

  // Register write starts a rate pass, input closed next cycle
  a_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=> !s_axis_tready)
    else $error("input open right after register write");

  // Rate pass after reset
  a_rst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input open right after reset");

endmodule

bind wave_height_field_point_unit whfp_checker u_whfp_checker (.*);

// ===== dv/wave_height_field_point_unit_tb.sv =====
// ----------------------------------------------------------------------------
// wave_height_field_point_unit_tb: self-checking bench for the wave height unit
// Streams grid points through the unit under changing register settings and
// random stalls on both sides. Each result is checked against a bit-true
// fixed-point height predictor (straight wave plus ring pulse) or typed-in zero.
// ----------------------------------------------------------------------------
module wave_height_field_point_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;  // no register; write sets nothing
  localparam int PIPE_LATENCY = 96;
  localparam int CHUNK_POINTS = 65;
  localparam int CHUNKS = 10;
  localparam longint unsigned INV_2PI = 64'd683565276;
  localparam longint unsigned INV_RT2 = 64'd3037000500;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint unsigned TWO32 = 64'h1_0000_0000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] z;
    logic [31:0]        ts;
    logic [31:0]        tr;
    logic               act;
  } point_t;

  typedef struct {
    logic signed [15:0] h;
    logic               sat;
  } height_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [95:0] s_axis_tdata;   // point_x, point_z, straight_time, ring_time
  logic [0:0]  s_axis_tuser;   // ring_active
  logic [15:0] m_axis_tdata;   // height
  logic [0:0]  m_axis_tuser;   // saturated
  logic psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  // bench copy of the registers
  logic [7:0]  s_wl, s_gain, r_wl, r_gain;
  logic [15:0] org_x, org_z, grav;

  height_t height_q[$];
  int errors = 0;
  int n_points = 0;
  int n_heights = 0;
  int n_sat = 0;
  int n_ring = 0;
  int src_idle = 0;
  int snk_idle = 0;
  logic snk_hold = 1'b0;
  event hold_go;

  wave_height_field_point_unit dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned len_of(logic [7:0] l);
    return (l == 0) ? 64'd1 : 64'(l);
  endfunction

  // turns per second, Q.28
  function automatic longint unsigned wave_rate(logic [7:0] l);
    return int_sqrt(((64'(grav) * INV_2PI) << 16) / len_of(l));
  endfunction

  function automatic longint unsigned ring_period(logic signed [15:0] x,
                                                  logic signed [15:0] z);
    longint dx, dz;
    longint unsigned sq;
    dx = longint'(x) - longint'($signed(org_x));
    dz = longint'(z) - longint'($signed(org_z));
    sq = longint'(dx * dx) + longint'(dz * dz);
    return (int_sqrt(sq << 20) << 16) / len_of(r_wl);
  endfunction

  function automatic longint sine_q30(logic [31:0] ang);
    longint zz, xx, yy, dx, dy;
    logic [29:0] at;
    zz = longint'(ang);
    xx = GAIN_Q30;
    yy = 0;
    if (zz >= (64'sd1 <<< 31)) zz = zz - (64'sd1 <<< 32);
    if (zz > (64'sd1 <<< 30)) zz = (64'sd1 <<< 31) - zz;
    else if (zz < -(64'sd1 <<< 30)) zz = -(64'sd1 <<< 31) - zz;
    for (int i = 0; i < 16 && i < 24; i++) begin
      dx = yy >>> i;
      dy = xx >>> i;
      at = whfp_pkg::atan_turns(i);
      if (zz >= 0) begin
        xx -= dx; yy += dy; zz -= longint'(at);
      end else begin
        xx += dx; yy -= dy; zz += longint'(at);
      end
    end
    return yy;
  endfunction

  // amplitude scaling with round half away from zero
  function automatic longint wave_amp(logic [31:0] ang, logic [7:0] g, logic [7:0] l);
    longint s;
    longint unsigned m, d, q;
    s = sine_q30(ang);
    m = (s < 0) ? longint'(-s) : longint'(s);
    m = m * 64'(g) * 64'(l);
    d = 64'd14 << 28;
    q = (m + d / 2) / d;
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic height_t predict_height(point_t p);
    height_t r;
    longint sum, s, per;
    longint unsigned q, ph, rp;
    s = longint'(p.x) + longint'(p.z);
    q = ((s < 0) ? longint'(-s) : longint'(s)) * INV_RT2 / (64 * len_of(s_wl));
    per = (s < 0) ? -longint'(q) : longint'(q);
    ph = (64'(p.ts) * wave_rate(s_wl)) >> 12;
    sum = wave_amp(32'(longint'(per) - longint'(ph)), s_gain, s_wl);
    if (p.act) begin
      rp = ring_period(p.x, p.z);
      ph = (64'(p.tr) * wave_rate(r_wl)) >> 12;
      if (ph >= rp && ph - rp < TWO32) begin
        sum += wave_amp(32'(rp - ph), r_gain, r_wl);
        n_ring++;
      end
    end
    r.sat = 1'b1;
    if (sum > 32767) r.h = 16'sh7fff;
    else if (sum < -32768) r.h = 16'sh8000;
    else begin
      r.h = 16'(sum);
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // ---------------- config port ----------------
  task automatic set_reg(logic [2:0] idx, logic [15:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {16'($urandom_range(65535)), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      whfp_pkg::REG_STRAIGHT_WL:   s_wl = val[7:0];
      whfp_pkg::REG_STRAIGHT_GAIN: s_gain = val[7:0];
      whfp_pkg::REG_RING_WL:       r_wl = val[7:0];
      whfp_pkg::REG_RING_GAIN:     r_gain = val[7:0];
      whfp_pkg::REG_RING_ORG_X:    org_x = val;
      whfp_pkg::REG_RING_ORG_Z:    org_z = val;
      whfp_pkg::REG_GRAVITY:       grav = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (height_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  // ---------------- input side ----------------
  // known: expectation typed in by the caller instead of predicted
  task automatic send_point(point_t p, bit known, height_t kv);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {p.tr, p.ts, p.z, p.x};
    s_axis_tuser <= p.act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    height_q.insert(height_q.size(), known ? kv : predict_height(p));
    n_points++;
  endtask

  function automatic point_t rand_point();
    point_t p;
    longint unsigned rate, t;
    int mode;
    mode = $urandom_range(99);
    p.x = 16'($urandom);
    p.z = 16'($urandom);
    p.ts = $urandom;
    p.tr = $urandom;
    p.act = 1'($urandom);
    if (mode < 25) begin
      // small field near the origin, short ring times
      p.x = 16'($signed(16'($urandom_range(8191))) - 16'sd4096);
      p.z = 16'($signed(16'($urandom_range(8191))) - 16'sd4096);
      p.tr = $urandom_range(32'h003f_ffff);
    end else if (mode < 85) begin
      // ring pulse: pick a ring time that lands inside the window
      p.act = 1'b1;
      p.x = 16'($signed(org_x) + $signed(16'($urandom_range(8191))) - 16'sd4096);
      p.z = 16'($signed(org_z) + $signed(16'($urandom_range(8191))) - 16'sd4096);
      rate = wave_rate(r_wl);
      if (rate != 0) begin
        t = ((ring_period(p.x, p.z) + 64'($urandom)) << 12) / rate;
        if (t < TWO32) p.tr = 32'(t + $urandom_range(1));
      end
    end
    return p;
  endfunction

  // ---------------- output side ----------------
  always @(posedge clk) begin
    height_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_heights++;
        if (m_axis_tuser[0]) n_sat++;
        if (height_q.size() == 0) begin
          $display("%0t: height %0d with nothing expected", $time,
                   $signed(m_axis_tdata));
          errors++;
        end else begin
          e = height_q.pop_front();
          if (m_axis_tdata !== e.h) begin
            $display("%0t: height expected %0d actual %0d", $time, e.h,
                     $signed(m_axis_tdata));
            errors++;
          end
          if (m_axis_tuser[0] !== e.sat) begin
            $display("%0t: saturated expected %0b actual %0b", $time, e.sat,
                     m_axis_tuser[0]);
            errors++;
          end
        end
      end
      m_axis_tready <= !snk_hold && ($urandom_range(99) >= snk_idle);
    end
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin
    @(hold_go);
    snk_hold = 1'b1;
    repeat (400) @(posedge clk);
    snk_hold = 1'b0;
  end

  // ---------------- stimulus ----------------
  point_t corner_pts[12];
  initial begin
    height_t zero_h;
    point_t p;
    zero_h.h = '0;
    zero_h.sat = 1'b0;
    s_axis_tvalid <= 1'b0; s_axis_tdata <= '0; s_axis_tuser <= '0;
    m_axis_tready <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    s_wl = 8'd50; s_gain = 8'd8; r_wl = 8'd40; r_gain = 8'd64;
    org_x = '0; org_z = '0; grav = 16'd2509;
    corner_pts = '{
      '{16'sd0, 16'sd0, 32'd0, 32'd0, 1'b0},
      '{16'sd0, 16'sd0, 32'd0, 32'd0, 1'b1},               // ring at its center
      '{16'sh7fff, 16'sh7fff, 32'hffff_ffff, 32'hffff_ffff, 1'b1},
      '{16'sh8000, 16'sh8000, 32'hffff_ffff, 32'd0, 1'b1},
      '{16'sh8000, 16'sh7fff, 32'h8000_0000, 32'h0001_0000, 1'b1},
      '{16'sh7fff, 16'sh8000, 32'h0000_0001, 32'hffff_ffff, 1'b0},
      '{16'sd64, 16'sd0, 32'h0001_0000, 32'h0000_8000, 1'b1},
      '{-16'sd64, 16'sd0, 32'h0010_0000, 32'h0010_0000, 1'b1},
      '{16'sd3200, 16'sd3200, 32'h7fff_ffff, 32'h0100_0000, 1'b1},
      '{16'sh5555, 16'shaaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b1},
      '{16'shaaaa, 16'sh5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0},
      '{16'sd1, -16'sd1, 32'd12345, 32'd0, 1'b1}
    };
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;

    // corner points at reset settings, then with both gains at zero
    src_idle = 20; snk_idle = 46;
    foreach (corner_pts[i]) send_point(corner_pts[i], 1'b0, zero_h);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    set_reg(whfp_pkg::REG_STRAIGHT_GAIN, 16'd0);
    set_reg(whfp_pkg::REG_RING_GAIN, 16'd0);
    set_reg(REG_UNUSED, 16'hffff);
    foreach (corner_pts[i]) send_point(corner_pts[i], 1'b1, zero_h);
    s_axis_tvalid <= 1'b0;

    // random points under a series of register settings
    for (int c = 0; c < CHUNKS; c++) begin
      wait_drained();
      if (c == 4) begin src_idle = 46; snk_idle = 20; end
      if (c == 7) begin src_idle = 0; snk_idle = 0; end
      case (c)
        0: begin  // zero wavelengths act as one, smallest nonzero gravity
          set_reg(whfp_pkg::REG_STRAIGHT_WL, 16'd0);
          set_reg(whfp_pkg::REG_STRAIGHT_GAIN, 16'd255);
          set_reg(whfp_pkg::REG_RING_WL, 16'd0);
          set_reg(whfp_pkg::REG_RING_GAIN, 16'd255);
          set_reg(whfp_pkg::REG_RING_ORG_X, 16'h8000);
          set_reg(whfp_pkg::REG_RING_ORG_Z, 16'h8000);
          set_reg(whfp_pkg::REG_GRAVITY, 16'd1);
        end
        1: begin  // largest everything, heights can saturate
          set_reg(whfp_pkg::REG_STRAIGHT_WL, 16'd255);
          set_reg(whfp_pkg::REG_STRAIGHT_GAIN, 16'd255);
          set_reg(whfp_pkg::REG_RING_WL, 16'd255);
          set_reg(whfp_pkg::REG_RING_GAIN, 16'd255);
          set_reg(whfp_pkg::REG_RING_ORG_X, 16'h7fff);
          set_reg(whfp_pkg::REG_RING_ORG_Z, 16'h7fff);
          set_reg(whfp_pkg::REG_GRAVITY, 16'hffff);
        end
        2: begin  // no gravity: phase frozen
          set_reg(whfp_pkg::REG_STRAIGHT_WL, 16'd1);
          set_reg(whfp_pkg::REG_RING_WL, 16'd1);
          set_reg(whfp_pkg::REG_RING_ORG_X, 16'd0);
          set_reg(whfp_pkg::REG_RING_ORG_Z, 16'd0);
          set_reg(whfp_pkg::REG_GRAVITY, 16'd0);
        end
        default: begin
          set_reg(whfp_pkg::REG_STRAIGHT_WL, 16'($urandom_range(255, 1)));
          set_reg(whfp_pkg::REG_STRAIGHT_GAIN, 16'($urandom_range(255)));
          set_reg(whfp_pkg::REG_RING_WL, 16'($urandom_range(255, 1)));
          set_reg(whfp_pkg::REG_RING_GAIN, 16'($urandom_range(255)));
          set_reg(whfp_pkg::REG_RING_ORG_X, 16'($urandom));
          set_reg(whfp_pkg::REG_RING_ORG_Z, 16'($urandom));
          set_reg(whfp_pkg::REG_GRAVITY, 16'($urandom_range(65535, 1)));
        end
      endcase
      if (c == 5) ->hold_go;
      for (int k = 0; k < CHUNK_POINTS; k++) begin
        if (c == 8 && k == CHUNK_POINTS / 2) begin
          // sender holds until the pipeline is empty
          s_axis_tvalid <= 1'b0;
          while (height_q.size() != 0) @(posedge clk);
        end
        p = rand_point();
        send_point(p, 1'b0, zero_h);
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    $display("covered %0d points, %0d heights checked, %0d saturated,", n_points,
             n_heights, n_sat);
    $display("%0d ring pulse hits across %0d register settings", n_ring, CHUNKS + 2);
    if (errors == 0 && height_q.size() == 0) begin
      $display("wave_height_field_point_unit: match");
    end else begin
      $display("wave_height_field_point_unit: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("timeout");
    $display("wave_height_field_point_unit: mismatch");
    $finish;
  end

endmodule
